FILE: hdl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BRA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property that must hold in the cycle after the antecedent
`define BRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/bra_pkg.sv
// shared constants and types of the bitmap run allocator
`timescale 1ns / 1ps

package bra_pkg;

	localparam int MAP_BITS   = 1024;
	localparam int WORD_BITS  = 32;
	localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W    = $clog2(WORD_COUNT);
	localparam int BOFF_W     = $clog2(WORD_BITS);
	localparam int IDX_W      = 10;
	localparam int LEN_W      = 11;
	localparam int ADDR_W     = 3;

	localparam logic [1:0] OP_FILL  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_TEST  = 2'd3;

	localparam logic [ADDR_W-3:0] REG_BITS_IN_USE = '0;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WADDR_W-1:0]   waddr_t;
	typedef logic [BOFF_W-1:0]    boff_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [LEN_W-1:0]     len_t;

	typedef struct packed {
		logic  hit;
		boff_t pos;
		len_t  run_out;
	} scan_res_t;

endpackage

FILE: hdl/bra_run_scan.sv
// one-word run search: first bit where the matching run reaches the needed length
`timescale 1ns / 1ps

module bra_run_scan (
	input  bra_pkg::word_t     match_word,
	input  bra_pkg::len_t      run_in,
	input  bra_pkg::len_t      need,
	output bra_pkg::scan_res_t res
);
	import bra_pkg::*;

	logic [WORD_BITS-1:0] zero_lvl [0:BOFF_W];
	boff_t                pos_lvl  [0:BOFF_W][0:WORD_BITS-1];
	len_t                 run_at   [0:WORD_BITS-1];
	logic [WORD_BITS-1:0] hit_vec;

	always_comb begin
		int j;
		for (int i = 0; i < WORD_BITS; i++) begin
			zero_lvl[0][i] = ~match_word[i];
			pos_lvl[0][i]  = boff_t'(i);
		end
		// nearest mismatch at or below each bit
		for (int l = 0; l < BOFF_W; l++) begin
			for (int i = 0; i < WORD_BITS; i++) begin
				j = (i >= (1 << l)) ? i - (1 << l) : i;
				if (i >= (1 << l) && !zero_lvl[l][i]) begin
					zero_lvl[l+1][i] = zero_lvl[l][j];
					pos_lvl[l+1][i]  = pos_lvl[l][j];
				end else begin
					zero_lvl[l+1][i] = zero_lvl[l][i];
					pos_lvl[l+1][i]  = pos_lvl[l][i];
				end
			end
		end
		for (int i = 0; i < WORD_BITS; i++) begin
			if (zero_lvl[BOFF_W][i]) begin
				run_at[i] = len_t'(boff_t'(i) - pos_lvl[BOFF_W][i]);
			end else begin
				run_at[i] = run_in + len_t'(i + 1);
			end
			hit_vec[i] = (run_at[i] >= need);
		end
		res.hit = |hit_vec;
		res.pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				res.pos = boff_t'(i);
			end
		end
		if (zero_lvl[BOFF_W][WORD_BITS-1]) begin
			res.run_out = len_t'(boff_t'(WORD_BITS - 1) - pos_lvl[BOFF_W][WORD_BITS-1]);
		end else begin
			res.run_out = run_in + len_t'(WORD_BITS);
		end
	end

endmodule

FILE: hdl/bitmap_run_allocator.sv
// First-fit bitmap allocator over 1024 bits held in a 32 x 32 synchronous memory.
// Every transaction gives exactly one result. The memory has one read and one
// write port and is visited one word per cycle. Fill needs no memory access;
// test reads one word; write range visits each word touched; and allocate
// visits each word scanned and then, when a run of nonzero length is found,
// each word marked. One transaction is worked on at a time; a finished result
// waits in the output register. Reset clears the map at once through per-word
// valid flags, so no clearing pass is needed.
`timescale 1ns / 1ps

module bitmap_run_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  opcode,
	input  bra_pkg::idx_t               bit_index,
	input  bra_pkg::len_t               run_length,
	input  logic                        bit_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output bra_pkg::idx_t               start_index,
	output logic                        bit_read,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bra_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import bra_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_MARK     = 3'd2;
	localparam logic [2:0] S_MARK_END = 3'd3;
	localparam logic [2:0] S_TEST     = 3'd4;
	localparam logic [2:0] S_TEST_RD  = 3'd5;
	localparam logic [2:0] S_FIN      = 3'd6;

	logic [2:0]            state_q;
	len_t                  biu_q;
	logic                  fill_q;
	logic [WORD_COUNT-1:0] valid_q;

	word_t  mem [0:WORD_COUNT-1];
	word_t  rd_q;
	logic   vld_s1;
	waddr_t w_s1;
	logic   scan_s1;
	logic   mark_s1;

	waddr_t ptr_q, we_q, wl_q;
	len_t   lo_q, hi_q, run_q, need_q, len_q;
	logic   val_q;
	idx_t   idx_q;
	logic   res_found_q, res_bit_q;
	idx_t   res_start_q;
	logic   out_valid_q, found_q, bit_read_q;
	idx_t   start_q;

	len_t       lim, lim_m1, hi_wr, hi_m1, hit_start, hit_end, hit_m1;
	logic [LEN_W:0] end_sum;
	logic       wr_empty;
	word_t      rdata, match_word, mark_mask, wr_data;
	logic       rd_en;
	waddr_t     rd_addr;
	scan_res_t  sres;
	logic       cfg_wr, out_load;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (paddr[ADDR_W-1:2] == REG_BITS_IN_USE) ? 32'(biu_q) : '0;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign start_index = start_q;
	assign bit_read    = bit_read_q;
	assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign lim     = (biu_q > len_t'(MAP_BITS)) ? len_t'(MAP_BITS) : biu_q;
	assign lim_m1  = lim - len_t'(1);
	assign end_sum = (LEN_W+1)'(bit_index) + (LEN_W+1)'(run_length);
	assign hi_wr   = (end_sum > (LEN_W+1)'(lim)) ? lim : end_sum[LEN_W-1:0];
	assign hi_m1   = hi_wr - len_t'(1);
	assign wr_empty = (len_t'(bit_index) >= hi_wr);
	assign rdata   = vld_s1 ? rd_q : {WORD_BITS{fill_q}};

	assign hit_start = len_t'({w_s1, sres.pos}) + len_t'(1) - need_q;
	assign hit_end   = hit_start + len_q;
	assign hit_m1    = hit_end - len_t'(1);

	always_comb begin
		len_t bit_abs;
		for (int b = 0; b < WORD_BITS; b++) begin
			bit_abs       = len_t'({w_s1, boff_t'(b)});
			match_word[b] = (rdata[b] == val_q) && (bit_abs < lim);
			mark_mask[b]  = (bit_abs >= lo_q) && (bit_abs < hi_q);
		end
		wr_data = val_q ? (rdata | mark_mask) : (rdata & ~mark_mask);
	end

	bra_run_scan u_scan (
		.match_word (match_word),
		.run_in     (run_q),
		.need       (need_q),
		.res        (sres)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		case (state_q)
			S_SCAN, S_MARK: begin
				rd_en = 1'b1;
			end
			S_TEST: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[IDX_W-1:BOFF_W];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// bitmap memory, read-modify-write one word per cycle
	always_ff @(posedge clk) begin
		if (mark_s1) begin
			mem[w_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		w_s1   <= rd_addr;
		vld_s1 <= valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= 1'b0;
			mark_s1 <= 1'b0;
		end else begin
			scan_s1 <= (state_q == S_SCAN);
			mark_s1 <= (state_q == S_MARK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q <= len_t'(MAP_BITS);
		end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_BITS_IN_USE) begin
			biu_q <= pwdata[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= 1'b0;
			valid_q     <= '0;
			ptr_q       <= '0;
			we_q        <= '0;
			wl_q        <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			run_q       <= '0;
			need_q      <= '0;
			len_q       <= '0;
			val_q       <= 1'b0;
			idx_q       <= '0;
			res_found_q <= 1'b0;
			res_start_q <= '0;
			res_bit_q   <= 1'b0;
		end else begin
			if (mark_s1) begin
				valid_q[w_s1] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q       <= bit_index;
						len_q       <= run_length;
						val_q       <= bit_value;
						need_q      <= (run_length == '0) ? len_t'(1) : run_length;
						res_found_q <= (opcode != OP_ALLOC) || (lim != '0);
						res_start_q <= '0;
						res_bit_q   <= 1'b0;
						case (opcode)
							OP_FILL: begin
								valid_q <= '0;
								fill_q  <= bit_value;
								state_q <= S_FIN;
							end
							OP_ALLOC: begin
								ptr_q <= '0;
								run_q <= '0;
								wl_q  <= lim_m1[IDX_W-1:BOFF_W];
								if (lim == '0) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_WRITE: begin
								lo_q  <= len_t'(bit_index);
								hi_q  <= hi_wr;
								ptr_q <= bit_index[IDX_W-1:BOFF_W];
								we_q  <= hi_m1[IDX_W-1:BOFF_W];
								state_q <= wr_empty ? S_FIN : S_MARK;
							end
							default: begin
								state_q <= S_TEST;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!(scan_s1 && sres.hit && len_q != '0)) begin
						ptr_q <= ptr_q + waddr_t'(1);
					end
					if (scan_s1) begin
						if (sres.hit) begin
							res_start_q <= hit_start[IDX_W-1:0];
							if (len_q != '0) begin
								lo_q    <= hit_start;
								hi_q    <= hit_end;
								ptr_q   <= hit_start[IDX_W-1:BOFF_W];
								we_q    <= hit_m1[IDX_W-1:BOFF_W];
								val_q   <= 1'b1;
								state_q <= S_MARK;
							end else begin
								state_q <= S_FIN;
							end
						end else if (w_s1 == wl_q) begin
							res_found_q <= 1'b0;
							state_q     <= S_FIN;
						end else begin
							run_q <= sres.run_out;
						end
					end
				end
				S_MARK: begin
					if (ptr_q == we_q) begin
						state_q <= S_MARK_END;
					end else begin
						ptr_q <= ptr_q + waddr_t'(1);
					end
				end
				S_MARK_END: begin
					state_q <= S_FIN;
				end
				S_TEST: begin
					state_q <= S_TEST_RD;
				end
				S_TEST_RD: begin
					res_bit_q <= rdata[idx_q[BOFF_W-1:0]];
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			start_q     <= '0;
			bit_read_q  <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			found_q     <= res_found_q;
			start_q     <= res_start_q;
			bit_read_q  <= res_bit_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hdl/bra_checker.sv
// port-level checks of the bitmap run allocator and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [9:0]  start_index,
	input logic        bit_read,
	input logic        pready
);

	`BRA_ASSERT(a_pready_high, pready, "pready dropped")
	`BRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(start_index) && $stable(bit_read), "stalled result changed")
	`BRA_ASSERT(a_miss_zero_start, !(out_valid && !found) || start_index == 10'd0, "failed allocation with nonzero start")
	`BRA_ASSERT(a_test_fields, !(out_valid && bit_read) || (found && start_index == 10'd0), "test result with allocation fields set")
	`BRA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second transaction taken while busy")

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);

FILE: bench/tb_top.sv
// testbench for bitmap_run_allocator: directed and random transactions checked against a bit-level model
`timescale 1ns / 1ps

module tb_top;
	import bra_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_ITEMS = 135;
	localparam int PHASE_COUNT = 12;
	localparam int LONG_HOLD = 400;
	localparam logic [ADDR_W-1:0] BITS_IN_USE_ADDR = {REG_BITS_IN_USE, 2'b00};

	typedef struct packed {
		logic [1:0] op;
		idx_t       index;
		len_t       length;
		logic       value;
	} alloc_req_t;

	typedef struct packed {
		logic found;
		idx_t start;
		logic bit_read;
	} alloc_resp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = OP_FILL;
	idx_t        bit_index = '0;
	len_t        run_length = '0;
	logic        bit_value = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	idx_t        start_index;
	logic        bit_read;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// bit-level copy of the map and the used-size register
	logic [MAP_BITS-1:0] map_model = '0;
	len_t                cfg_bits_in_use = 11'd1024;

	alloc_req_t  request_queue[$];
	alloc_resp_t predicted_replies[$];
	alloc_req_t  next_req;
	alloc_resp_t want;

	int   cfg_plan [PHASE_COUNT] = '{1024, 0, 1, 2047, 33, 32, 31, 1000, 0, 1024, 64, 1025};
	int   error_count = 0;
	int   cycle_count = 0;
	int   in_gap_left = 0;
	int   rx_hold_left = 0;
	int   long_hold_req = 0;
	bit   tx_idling = 1'b1;
	bit   rx_idling = 1'b1;
	bit   in_taken = 1'b0;

	bitmap_run_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.bit_index(bit_index),
		.run_length(run_length),
		.bit_value(bit_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.start_index(start_index),
		.bit_read(bit_read),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		error_count++;
		$display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, exp_val);
	endtask

	function automatic int used_limit();
		return (cfg_bits_in_use > MAP_BITS) ? MAP_BITS : int'(cfg_bits_in_use);
	endfunction

	function automatic void mark_range(input int first, input int count, input logic v,
			input int lim);
		for (int i = 0; i < count && first + i < lim; i++)
			map_model[first + i] = v;
	endfunction

	function automatic alloc_resp_t apply_request(input logic [1:0] op, input idx_t index,
			input len_t length, input logic value);
		alloc_resp_t resp;
		int lim;
		int need;
		int run_len;
		int first;
		lim = used_limit();
		resp.found = 1'b1;
		resp.start = '0;
		resp.bit_read = 1'b0;
		case (op)
			OP_FILL: begin
				map_model = {MAP_BITS{value}};
			end
			OP_ALLOC: begin
				need = (length == 0) ? 1 : int'(length);
				run_len = 0;
				first = 0;
				resp.found = 1'b0;
				for (int i = 0; i < lim; i++) begin
					if (map_model[i] == value) begin
						run_len++;
						if (run_len == need) begin
							resp.found = 1'b1;
							first = i + 1 - need;
							break;
						end
					end else begin
						run_len = 0;
					end
				end
				resp.start = idx_t'(first);
				if (resp.found && length != 0)
					mark_range(first, int'(length), 1'b1, lim);
			end
			OP_WRITE: begin
				mark_range(int'(index), int'(length), value, lim);
			end
			default: begin
				resp.bit_read = map_model[index];
			end
		endcase
		return resp;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 10);
		return $urandom_range(20, 80);
	endfunction

	function automatic len_t random_length();
		int s;
		s = $urandom_range(0, 99);
		if (s < 5)
			return '0;
		if (s < 65)
			return len_t'($urandom_range(1, 8));
		if (s < 90)
			return len_t'($urandom_range(9, 64));
		return len_t'($urandom_range(65, 2047));
	endfunction

	function automatic idx_t random_index(input int lim);
		int s;
		s = $urandom_range(0, 99);
		if (lim == 0 || s < 15)
			return idx_t'($urandom_range(0, 1023));
		if (s < 25)
			return idx_t'($urandom_range((lim > 8) ? lim - 8 : 0, lim - 1));
		return idx_t'($urandom_range(0, lim - 1));
	endfunction

	function automatic alloc_req_t random_request(input int lim);
		alloc_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.index = idx_t'($urandom_range(0, 1023));
		r.length = random_length();
		r.value = ($urandom_range(0, 99) < 70) ? 1'b0 : 1'b1;
		if (pick < 8) begin
			r.op = OP_FILL;
		end else if (pick < 48) begin
			r.op = OP_ALLOC;
		end else if (pick < 73) begin
			r.op = OP_WRITE;
			r.index = random_index(lim);
			r.value = ($urandom_range(0, 99) < 60) ? 1'b0 : 1'b1;
		end else begin
			r.op = OP_TEST;
			r.index = random_index(lim);
		end
		return r;
	endfunction

	task automatic push_req(input logic [1:0] op, input int index, input int length,
			input logic value);
		alloc_req_t r;
		r.op = op;
		r.index = idx_t'(index);
		r.length = len_t'(length);
		r.value = value;
		request_queue.push_back(r);
	endtask

	task automatic push_random(input int count);
		repeat (count)
			request_queue.push_back(random_request(used_limit()));
	endtask

	task automatic wait_idle();
		while (request_queue.size() != 0 || in_valid || predicted_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bits_in_use(input len_t v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BITS_IN_USE_ADDR;
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cfg_bits_in_use = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(v))
			report_mismatch("bits_in_use readback", int'(prdata), int'(v));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_gap_left > 0) begin
				in_gap_left--;
				in_valid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				next_req = request_queue.pop_front();
				opcode <= next_req.op;
				bit_index <= next_req.index;
				run_length <= next_req.length;
				bit_value <= next_req.value;
				in_valid <= 1'b1;
				in_gap_left = (tx_idling && $urandom_range(0, 1)) ? gap_length() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (long_hold_req > 0) begin
			rx_hold_left = long_hold_req - 1;
			long_hold_req = 0;
			out_ready <= 1'b0;
		end else if (rx_idling && $urandom_range(0, 99) < 20) begin
			rx_hold_left = gap_length() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				predicted_replies.push_back(apply_request(opcode, bit_index, run_length, bit_value));
			end
			if (out_valid && out_ready) begin
				if (predicted_replies.size() == 0) begin
					report_mismatch("unexpected transaction", int'(start_index), 0);
				end else begin
					want = predicted_replies.pop_front();
					if (found !== want.found)
						report_mismatch("found", int'(found), int'(want.found));
					if (start_index !== want.start)
						report_mismatch("start_index", int'(start_index), int'(want.start));
					if (bit_read !== want.bit_read)
						report_mismatch("bit_read", int'(bit_read), int'(want.bit_read));
				end
			end
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		cfg_plan[8] = $urandom_range(2, 1023);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_req(OP_TEST, 0, 0, 1'b0);
		push_req(OP_TEST, 1023, 0, 1'b0);
		push_req(OP_ALLOC, 0, 0, 1'b0);
		push_req(OP_ALLOC, 0, 0, 1'b1);
		push_req(OP_ALLOC, 0, 1, 1'b0);
		push_req(OP_ALLOC, 0, 5, 1'b0);
		push_req(OP_ALLOC, 0, 1024, 1'b0);
		push_req(OP_WRITE, 1020, 2047, 1'b1);
		push_req(OP_TEST, 1023, 0, 1'b0);
		push_req(OP_FILL, 0, 0, 1'b0);
		push_req(OP_ALLOC, 0, 1024, 1'b0);
		push_req(OP_ALLOC, 0, 1, 1'b0);
		push_req(OP_ALLOC, 0, 0, 1'b1);
		push_req(OP_FILL, 1023, 2047, 1'b1);
		push_req(OP_ALLOC, 0, 0, 1'b0);
		push_req(OP_WRITE, 100, 3, 1'b0);
		push_req(OP_ALLOC, 0, 4, 1'b0);
		push_req(OP_ALLOC, 0, 3, 1'b0);
		// free run at the very end of the map
		push_req(OP_WRITE, 1022, 2, 1'b0);
		push_req(OP_ALLOC, 0, 3, 1'b0);
		push_req(OP_ALLOC, 0, 2, 1'b0);
		push_req(OP_ALLOC, 0, 2047, 1'b1);
		push_req(OP_WRITE, 500, 0, 1'b0);
		push_req(OP_TEST, 500, 0, 1'b0);
		push_req(OP_WRITE, 1023, 1, 1'b0);
		push_req(OP_TEST, 1023, 0, 1'b1);
		wait_idle();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_bits_in_use(len_t'(cfg_plan[p]));
			@(posedge clk);
			tx_idling = (p % 3 != 1);
			rx_idling = tx_idling;
			if (p == 4) begin
				tx_idling = 1'b0;
				long_hold_req = LONG_HOLD;
			end
			push_random(PHASE_ITEMS / 2);
			wait_idle();
			push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			wait_idle();
		end

		repeat (100) @(posedge clk);
		if (predicted_replies.size() != 0)
			report_mismatch("transactions never returned", 0, predicted_replies.size());
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bra_pkg.sv
hdl/bra_run_scan.sv
hdl/bitmap_run_allocator.sv
hdl/bra_checker.sv
bench/tb_top.sv
